// File: design/hpq_pkg.sv
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types and constants for the handle-addressed priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_BITS  = 32;
  localparam int IDX_BITS  = $clog2(CAPACITY);
  localparam int RANK_BITS = IDX_BITS;
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);
  localparam int HCMP_BITS = IDX_BITS + 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELMAX = 2'd1,
    OP_CHANGE = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_EMPTY      = 2'd2,
    STAT_BAD_HANDLE = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef enum logic [1:0] {
    CC_NOP    = 2'd0,
    CC_INSERT = 2'd1,
    CC_WRITE  = 2'd2,
    CC_FREE   = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] key;
    logic [3:0]  handle;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] key_out;
    logic [3:0]  handle_out;
    logic        is_empty;
    logic [4:0]  entry_count;
  } out_item_t;

  // Broadcast command from the controller to every cell.
  typedef struct packed {
    cell_cmd_t             cmd;
    logic [KEY_BITS-1:0]   key;
    logic [RANK_BITS-1:0]  rank;
  } cell_ctl_t;

  // Search token handed from cell to cell during a delete-max scan.
  typedef struct packed {
    logic                  tvalid;
    logic                  found;
    logic [IDX_BITS-1:0]   pos;
    logic [IDX_BITS-1:0]   idx;
    logic [KEY_BITS-1:0]   key;
    logic [RANK_BITS-1:0]  rank;
  } scan_tok_t;

endpackage

// File: design/hpq_cell.sv
// ----------------------------------------------------------------------------
// hpq_cell
// One queue slot: valid bit, key and age rank, plus one stage of the
// delete-max search token.
// ----------------------------------------------------------------------------
module hpq_cell
  import hpq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_ctl_t            ctl,
  input  logic                 sel,
  input  scan_tok_t            tok_i,
  output scan_tok_t            tok_o,
  output logic                 valid_o,
  output logic [RANK_BITS-1:0] rank_o
);

  logic                 valid_r, valid_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [RANK_BITS-1:0] rank_r, rank_nxt;
  scan_tok_t            tok_r, tok_nxt;
  logic                 take;

  // Slot update from the broadcast command.
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    rank_nxt  = rank_r;
    case (ctl.cmd)
      CC_INSERT: begin
        if (sel) begin
          valid_nxt = 1'b1;
          key_nxt   = ctl.key;
          rank_nxt  = '0;
        end else if (valid_r) begin
          rank_nxt = rank_r + RANK_BITS'(1);
        end
      end
      CC_WRITE: begin
        if (sel) begin
          key_nxt = ctl.key;
        end
      end
      CC_FREE: begin
        if (sel) begin
          valid_nxt = 1'b0;
        end else if (valid_r && (rank_r > ctl.rank)) begin
          rank_nxt = rank_r - RANK_BITS'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Take over the token when this slot beats the best so far; ties go newest.
  assign take = tok_i.tvalid && valid_r &&
                (!tok_i.found || (key_r > tok_i.key) ||
                 ((key_r == tok_i.key) && (rank_r < tok_i.rank)));

  always_comb begin
    tok_nxt     = tok_i;
    tok_nxt.pos = tok_i.pos + IDX_BITS'(1);
    if (take) begin
      tok_nxt.found = 1'b1;
      tok_nxt.idx   = tok_i.pos;
      tok_nxt.key   = key_r;
      tok_nxt.rank  = rank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    rank_r <= rank_nxt;
  end

  assign tok_o   = tok_r;
  assign valid_o = valid_r;
  assign rank_o  = rank_r;

endmodule

// File: design/handle_priority_queue.sv
// ----------------------------------------------------------------------------
// handle_priority_queue
// Fixed-capacity priority queue addressed by slot handles, built as a row
// of slot cells with a search token for delete-maximum.
// ----------------------------------------------------------------------------
//
//  channel   ports                     transfer when
//  --------  ------------------------  -------------------------------
//  command   start, busy, in_item      start high and busy low
//  result    out_strobe, out_item      out_strobe high (one cycle)
//
// Insert, change and delete-by-handle keep busy low, and the result strobes
// in the cycle after the command transfer.
// Delete-maximum holds busy high while a search token walks the row of slot
// cells one cell per cycle; when it leaves the last cell the winner is freed.
// Reset (rst_n low, synchronous) empties the queue and clears the token row.
// The receiver cannot stall; a result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module handle_priority_queue
  import hpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  state_t               state_r, state_nxt;
  logic [CNT_BITS-1:0]  count_r, count_nxt;
  out_item_t            out_item_r, out_item_nxt;
  logic                 out_strobe_r, out_strobe_nxt;

  cell_ctl_t            ctl;
  logic                 sel_en;
  logic [IDX_BITS-1:0]  sel_idx;
  logic [CAPACITY-1:0]  sel;
  logic [CAPACITY-1:0]  valid_vec;
  logic [RANK_BITS-1:0] rank_a [CAPACITY];
  scan_tok_t            tok [CAPACITY+1];

  logic                 accept;
  logic                 launch;
  logic [KEY_BITS-1:0]  key_k;
  logic [HCMP_BITS-1:0] h_ext;
  logic [IDX_BITS-1:0]  h_idx;
  logic                 h_ok;
  logic                 free_found;
  logic [IDX_BITS-1:0]  free_idx;
  scan_tok_t            tok_last;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && (state_r == ST_IDLE);
  assign launch = accept && (in_item.op == OP_DELMAX);

  // Hold keys to the stored key width.
  assign key_k = KEY_BITS'(in_item.key);

  // Handle check: in range and pointing at a live slot.
  assign h_ext = HCMP_BITS'(in_item.handle);
  assign h_idx = IDX_BITS'(in_item.handle);
  assign h_ok  = (h_ext < HCMP_BITS'(CAPACITY)) && valid_vec[h_idx];

  // Lowest free slot: walk down so the lowest index wins.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_vec[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_BITS'(i);
      end
    end
  end

  // Launch the search token into the first cell.
  always_comb begin
    tok[0]        = '0;
    tok[0].tvalid = launch;
  end

  assign tok_last = tok[CAPACITY];

  // Row of slot cells; the token advances one cell per cycle.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign sel[g] = sel_en && (sel_idx == IDX_BITS'(g));

    hpq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .sel     (sel[g]),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1]),
      .valid_o (valid_vec[g]),
      .rank_o  (rank_a[g])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (launch) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok_last.tvalid) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Cell commands, count and result.
  always_comb begin
    ctl.cmd        = CC_NOP;
    ctl.key        = key_k;
    ctl.rank       = rank_a[h_idx];
    sel_en         = 1'b0;
    sel_idx        = h_idx;
    count_nxt      = count_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = '0;
    out_item_nxt.status = STAT_OK;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_strobe_nxt = (in_item.op != OP_DELMAX);
          case (in_item.op)
            OP_INSERT: begin
              if (free_found) begin
                ctl.cmd                 = CC_INSERT;
                sel_en                  = 1'b1;
                sel_idx                 = free_idx;
                count_nxt               = count_r + CNT_BITS'(1);
                out_item_nxt.handle_out = 4'(free_idx);
              end else begin
                out_item_nxt.status = STAT_FULL;
              end
            end
            OP_CHANGE: begin
              if (h_ok) begin
                ctl.cmd = CC_WRITE;
                sel_en  = 1'b1;
              end else begin
                out_item_nxt.status = STAT_BAD_HANDLE;
              end
            end
            OP_DELETE: begin
              if (h_ok) begin
                ctl.cmd   = CC_FREE;
                sel_en    = 1'b1;
                count_nxt = count_r - CNT_BITS'(1);
              end else begin
                out_item_nxt.status = STAT_BAD_HANDLE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Token has left the last cell: free the winner and report it, or report empty.
        if (tok_last.tvalid) begin
          out_strobe_nxt = 1'b1;
          if (tok_last.found) begin
            ctl.cmd                 = CC_FREE;
            ctl.rank                = tok_last.rank;
            sel_en                  = 1'b1;
            sel_idx                 = tok_last.idx;
            count_nxt               = count_r - CNT_BITS'(1);
            out_item_nxt.key_out    = 32'(tok_last.key);
            out_item_nxt.handle_out = 4'(tok_last.idx);
          end else begin
            out_item_nxt.status = STAT_EMPTY;
          end
        end
      end
      default: begin
      end
    endcase

    out_item_nxt.is_empty    = (count_nxt == '0);
    out_item_nxt.entry_count = 5'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Result payload; only meaningful under the strobe.
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule
